// File: hw/rtl/rfid_frame_size_q_controller_top_defines.svh
// Assertion macros for the frame-size Q controller.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef RFID_FRAME_SIZE_Q_CONTROLLER_TOP_DEFINES_SVH
`define RFID_FRAME_SIZE_Q_CONTROLLER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RFSQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define RFSQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: hw/rtl/rfsq_pkg.sv
// Shared constants, codes and helper functions for the frame-size Q controller.
// No dependencies.
package rfsq_pkg;

   // Default parameter values
   localparam int MAX_Q_DEFAULT       = 15;
   localparam int Q_FRAC_BITS_DEFAULT = 12;

   // Field widths
   localparam int FRAME_W = 16;
   localparam int SLOT_W  = 15;
   localparam int STEP_W  = 12;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [FRAME_W-1:0] FRAME_MAX = 16'd32768;

   // Mode codes
   localparam logic [1:0] MODE_LOWER    = 2'd0;
   localparam logic [1:0] MODE_ADAPTIVE = 2'd1;
   localparam logic [1:0] MODE_FAST     = 2'd2;

   // Request kinds
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_OUTCOME = 1'b1;

   // Slot outcome codes
   localparam logic [1:0] SLOT_EMPTY     = 2'd0;
   localparam logic [1:0] SLOT_SINGLE    = 2'd1;
   localparam logic [1:0] SLOT_COLLISION = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_Q      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_FRAME  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_ADAPTIVE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_IDLE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COLLISION = 3'd5;

   // Register reset values
   localparam logic [1:0]         MODE_RESET           = MODE_LOWER;
   localparam logic [3:0]         INITIAL_Q_RESET      = 4'd4;
   localparam logic [FRAME_W-1:0] INITIAL_FRAME_RESET  = 16'd64;
   localparam logic [STEP_W-1:0]  STEP_ADAPTIVE_RESET  = 12'd819;
   localparam logic [STEP_W-1:0]  STEP_IDLE_RESET      = 12'd614;
   localparam logic [STEP_W-1:0]  STEP_COLLISION_RESET = 12'd868;

   // Frame size for a whole Q value: 2 to the power of it
   function automatic logic [FRAME_W-1:0] q_frame(input logic [3:0] whole);
      q_frame = FRAME_W'(1) << whole;
   endfunction

   // Force a configured frame into 1..32768
   function automatic logic [FRAME_W-1:0] clamp_frame(input logic [FRAME_W-1:0] f);
      if (f == '0) begin
         clamp_frame = FRAME_W'(1);
      end else if (f > FRAME_MAX) begin
         clamp_frame = FRAME_MAX;
      end else begin
         clamp_frame = f;
      end
   endfunction

endpackage

// File: hw/rtl/rfsq_q_step.sv
// Q step unit: scales a 1/4096 step to the Q fraction and applies it with clamping.
// Depends on rfsq_pkg.
module rfsq_q_step #(
   parameter int MAX_Q       = rfsq_pkg::MAX_Q_DEFAULT,
   parameter int Q_FRAC_BITS = rfsq_pkg::Q_FRAC_BITS_DEFAULT
) (
   input  logic [Q_FRAC_BITS+3:0]        q_cur,
   input  logic [rfsq_pkg::STEP_W-1:0]   step,
   input  logic                          increase,
   output logic [Q_FRAC_BITS+3:0]        q_next
);

   localparam int QW = Q_FRAC_BITS + 4;

   logic [Q_FRAC_BITS-1:0] step_scaled;
   logic [QW-1:0]          delta;
   logic [QW-1:0]          limit;
   logic [QW-1:0]          headroom;

   // Move the step onto the Q fraction scale; dropped low bits are lost
   generate
      if (Q_FRAC_BITS > rfsq_pkg::STEP_W) begin : g_shift_up
         assign step_scaled = {step, {(Q_FRAC_BITS - rfsq_pkg::STEP_W){1'b0}}};
      end else if (Q_FRAC_BITS == rfsq_pkg::STEP_W) begin : g_same
         assign step_scaled = step;
      end else begin : g_shift_down
         assign step_scaled = step[rfsq_pkg::STEP_W-1 -: Q_FRAC_BITS];
      end
   endgenerate

   assign delta    = {4'b0, step_scaled};
   assign limit    = {4'(MAX_Q), {Q_FRAC_BITS{1'b0}}};
   assign headroom = limit - q_cur;

   // Decrease stops at zero, increase stops at the upper limit
   always_comb begin
      if (increase) begin
         q_next = (headroom > delta) ? q_cur + delta : limit;
      end else begin
         q_next = (q_cur > delta) ? q_cur - delta : '0;
      end
   end

endmodule

// File: hw/rtl/rfid_frame_size_q_controller_top.sv
// Frame-size controller for framed slotted ALOHA inventory: returns each request's
// result in the next cycle from a result register, ready for a new request when that
// register is empty or is being taken in the same cycle, so a steady stream runs at
// one request per clock while results are taken; the single pass of Q step, clamp
// and frame selection sets that figure. The user must write configuration through
// the plain write port only while idle; the block does not enforce it. Depends on
// rfsq_pkg, rfsq_q_step and rfid_frame_size_q_controller_top_defines.svh.
`include "rfid_frame_size_q_controller_top_defines.svh"

module rfid_frame_size_q_controller_top #(
   parameter int MAX_Q       = rfsq_pkg::MAX_Q_DEFAULT,
   parameter int Q_FRAC_BITS = rfsq_pkg::Q_FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration
   input  logic                              csr_wr_en,
   input  logic [rfsq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfsq_pkg::CSR_W-1:0]        csr_wdata,
   // Requests
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [15:0]                       req_collisions,
   input  logic [1:0]                        req_slot_outcome,
   // Results
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rfsq_pkg::FRAME_W-1:0]      rsp_frame_size,
   output logic                              rsp_holding,
   output logic [rfsq_pkg::SLOT_W-1:0]       rsp_next_slot,
   output logic [3:0]                        rsp_q_whole
);

   localparam int QW = Q_FRAC_BITS + 4;
   localparam logic [3:0] RESET_IQ = (int'(rfsq_pkg::INITIAL_Q_RESET) > MAX_Q) ?
                                     4'(MAX_Q) : rfsq_pkg::INITIAL_Q_RESET;

   // Configuration registers
   logic [1:0]                       mode_ff;
   logic [3:0]                       initial_q_ff;
   logic [rfsq_pkg::FRAME_W-1:0]     initial_frame_ff;
   logic [rfsq_pkg::STEP_W-1:0]      step_adaptive_ff;
   logic [rfsq_pkg::STEP_W-1:0]      step_idle_ff;
   logic [rfsq_pkg::STEP_W-1:0]      step_collision_ff;

   // Controller state
   logic [QW-1:0]                    q_ff, q_in;
   logic [rfsq_pkg::FRAME_W-1:0]     frame_ff, frame_in;
   logic                             hold_ff, hold_in;
   logic [rfsq_pkg::SLOT_W-1:0]      slot_ff, slot_in;

   // Result register
   logic                             rsp_valid_ff;
   logic [rfsq_pkg::FRAME_W-1:0]     rsp_frame_ff;
   logic                             rsp_holding_ff;
   logic [rfsq_pkg::SLOT_W-1:0]      rsp_slot_ff;
   logic [3:0]                       rsp_q_whole_ff;

   logic                             req_accept;
   logic [3:0]                       iq_clamped;
   logic [QW-1:0]                    q_load;
   logic [QW-1:0]                    q_stepped;
   logic [rfsq_pkg::STEP_W-1:0]      step_sel;
   logic                             step_increase;
   logic [16:0]                      coll_double;
   logic [rfsq_pkg::FRAME_W-1:0]     lower_frame;
   logic                             outcome_moves_q;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= rfsq_pkg::MODE_RESET;
         initial_q_ff      <= rfsq_pkg::INITIAL_Q_RESET;
         initial_frame_ff  <= rfsq_pkg::INITIAL_FRAME_RESET;
         step_adaptive_ff  <= rfsq_pkg::STEP_ADAPTIVE_RESET;
         step_idle_ff      <= rfsq_pkg::STEP_IDLE_RESET;
         step_collision_ff <= rfsq_pkg::STEP_COLLISION_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rfsq_pkg::CSR_MODE:           mode_ff           <= csr_wdata[1:0];
            rfsq_pkg::CSR_INITIAL_Q:      initial_q_ff      <= csr_wdata[3:0];
            rfsq_pkg::CSR_INITIAL_FRAME:  initial_frame_ff  <= csr_wdata;
            rfsq_pkg::CSR_STEP_ADAPTIVE:  step_adaptive_ff  <= csr_wdata[11:0];
            rfsq_pkg::CSR_STEP_IDLE:      step_idle_ff      <= csr_wdata[11:0];
            rfsq_pkg::CSR_STEP_COLLISION: step_collision_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // Start value of Q, clamped to the upper limit
   assign iq_clamped = (int'(initial_q_ff) > MAX_Q) ? 4'(MAX_Q) : initial_q_ff;
   assign q_load     = {iq_clamped, {Q_FRAC_BITS{1'b0}}};

   // Lower-bound frame: twice the collisions, saturated, fallback on zero
   assign coll_double = {req_collisions, 1'b0};
   always_comb begin
      if (coll_double == '0) begin
         lower_frame = rfsq_pkg::clamp_frame(initial_frame_ff);
      end else if (coll_double > {1'b0, rfsq_pkg::FRAME_MAX}) begin
         lower_frame = rfsq_pkg::FRAME_MAX;
      end else begin
         lower_frame = coll_double[15:0];
      end
   end

   // Pick the Q step for the active rule
   assign step_increase   = (req_slot_outcome == rfsq_pkg::SLOT_COLLISION);
   assign outcome_moves_q = (req_slot_outcome == rfsq_pkg::SLOT_EMPTY) || step_increase;
   always_comb begin
      if (mode_ff == rfsq_pkg::MODE_ADAPTIVE) begin
         step_sel = step_adaptive_ff;
      end else if (req_slot_outcome == rfsq_pkg::SLOT_EMPTY) begin
         step_sel = step_idle_ff;
      end else begin
         step_sel = step_collision_ff;
      end
   end

   rfsq_q_step #(
      .MAX_Q       (MAX_Q),
      .Q_FRAC_BITS (Q_FRAC_BITS)
   ) u_q_step (
      .q_cur    (q_ff),
      .step     (step_sel),
      .increase (step_increase),
      .q_next   (q_stepped)
   );

   // Next controller state for the request at the port
   always_comb begin
      q_in     = q_ff;
      frame_in = frame_ff;
      hold_in  = hold_ff;
      slot_in  = slot_ff;
      if (req_kind == rfsq_pkg::KIND_START) begin
         q_in    = q_load;
         hold_in = 1'b0;
         slot_in = '0;
         if (mode_ff == rfsq_pkg::MODE_ADAPTIVE || mode_ff == rfsq_pkg::MODE_FAST) begin
            frame_in = rfsq_pkg::q_frame(q_load[Q_FRAC_BITS +: 4]);
         end else begin
            frame_in = rfsq_pkg::clamp_frame(initial_frame_ff);
         end
      end else begin
         unique case (mode_ff)
            rfsq_pkg::MODE_LOWER: begin
               hold_in  = 1'b0;
               slot_in  = '0;
               frame_in = lower_frame;
            end
            rfsq_pkg::MODE_ADAPTIVE: begin
               hold_in = 1'b0;
               slot_in = '0;
               if (outcome_moves_q) begin
                  q_in = q_stepped;
               end
               frame_in = rfsq_pkg::q_frame(q_in[Q_FRAC_BITS +: 4]);
            end
            rfsq_pkg::MODE_FAST: begin
               // Empty or collided slot moves Q and ends the hold
               if (outcome_moves_q) begin
                  q_in    = q_stepped;
                  hold_in = 1'b0;
                  slot_in = '0;
               end else if (hold_ff) begin
                  slot_in = slot_ff + 1'b1;
               end else begin
                  hold_in = 1'b1;
                  slot_in = rfsq_pkg::SLOT_W'(1);
               end
               if (!hold_in) begin
                  frame_in = rfsq_pkg::q_frame(q_in[Q_FRAC_BITS +: 4]);
               end
            end
            default: ;
         endcase
      end
   end

   // Advance state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff     <= {RESET_IQ, {Q_FRAC_BITS{1'b0}}};
         frame_ff <= rfsq_pkg::clamp_frame(rfsq_pkg::INITIAL_FRAME_RESET);
         hold_ff  <= 1'b0;
         slot_ff  <= '0;
      end else if (req_accept) begin
         q_ff     <= q_in;
         frame_ff <= frame_in;
         hold_ff  <= hold_in;
         slot_ff  <= slot_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_frame_ff   <= frame_in;
         rsp_holding_ff <= hold_in;
         rsp_slot_ff    <= hold_in ? slot_in : '0;
         rsp_q_whole_ff <= q_in[Q_FRAC_BITS +: 4];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_size = rsp_frame_ff;
   assign rsp_holding    = rsp_holding_ff;
   assign rsp_next_slot  = rsp_slot_ff;
   assign rsp_q_whole    = rsp_q_whole_ff;

   // Checks
   `RFSQ_ASSERT(a_q_in_range, q_ff <= {4'(MAX_Q), {Q_FRAC_BITS{1'b0}}}, "Q above limit")
   `RFSQ_ASSERT(a_slot_zero_unheld, rsp_valid && !rsp_holding |-> rsp_next_slot == '0,
                "next slot set without hold")
   `RFSQ_ASSERT(a_start_clears, req_accept && req_kind == rfsq_pkg::KIND_START |=>
                !hold_ff && slot_ff == '0, "start request left hold active")
   `RFSQ_ASSERT(a_accept_gives_rsp, req_accept |=> rsp_valid_ff, "accepted request lost")
   `RFSQ_ASSERT_ALWAYS(a_ready_when_empty, !rsp_valid_ff |-> req_ready,
                "request side stalled with empty result register")

endmodule
